[design/nearest_point_search_with_ties_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the nearest point search unit
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef NEAREST_POINT_SEARCH_WITH_TIES_UNIT_ASSERT_SVH
`define NEAREST_POINT_SEARCH_WITH_TIES_UNIT_ASSERT_SVH

`ifndef SYNTH
`define NPSWT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("npswt: implication check failed");
`define NPSWT_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("npswt: forbidden condition seen");
`else
`define NPSWT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define NPSWT_ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

[design/npswt_pkg.sv]
// ----------------------------------------------------------------------------
// npswt_pkg
// Types and constants shared by the nearest point search unit.
// ----------------------------------------------------------------------------
package npswt_pkg;

  localparam int COORD_W = 24;
  localparam int MAG_W   = COORD_W + 1;
  localparam int SQ_W    = 2 * COORD_W + 1;
  localparam int DIST_W  = SQ_W + 1;
  localparam int IDX_W   = 16;
  localparam int COUNT_W = 7;
  localparam int TOL_W   = 16;

  localparam logic [TOL_W-1:0] TOL_RESET = 16'd66;

  localparam int LIST_DEPTH_DEF = 64;
  localparam int INDEX_BITS_DEF = 16;

  localparam logic ACT_QUERY     = 1'b0;
  localparam logic ACT_CANDIDATE = 1'b1;

  typedef struct packed {
    logic                      action;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic [IDX_W-1:0]          point_index;
    logic                      last_candidate;
  } in_req_t;

  typedef struct packed {
    logic [IDX_W-1:0]   nearest_index;
    logic [COUNT_W-1:0] list_count;
    logic               list_overflow;
    logic               last_of_run;
  } out_res_t;

  typedef struct packed {
    logic              is_query;
    logic              last;
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] sq_dist;
  } dist_tok_t;

endpackage

[design/npswt_dist.sv]
// ----------------------------------------------------------------------------
// npswt_dist
// Three-stage squared distance pipeline and query point register.
// ----------------------------------------------------------------------------
module npswt_dist (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  npswt_pkg::in_req_t    in_req,
  input  logic                  advance,
  output logic                  tok_valid,
  output npswt_pkg::dist_tok_t  tok
);
  import npswt_pkg::*;

  logic signed [COORD_W-1:0] qx_r, qy_r;

  logic              a_valid_r, a_query_r, a_last_r;
  logic [IDX_W-1:0]  a_idx_r;
  logic [MAG_W-1:0]  mag_x_r, mag_y_r;

  logic              b_valid_r, b_query_r, b_last_r;
  logic [IDX_W-1:0]  b_idx_r;
  logic [SQ_W-1:0]   sq_x_r, sq_y_r;

  logic              c_valid_r;
  dist_tok_t         tok_r;

  logic signed [MAG_W-1:0] dx, dy;
  logic [MAG_W-1:0]        mag_x_nxt, mag_y_nxt;
  logic [2*MAG_W-1:0]      prod_x, prod_y;

  // Differences are taken against the query register at acceptance, so a
  // query updates the point seen by every later candidate.
  always_comb begin
    dx = {in_req.coord_x[COORD_W-1], in_req.coord_x} - {qx_r[COORD_W-1], qx_r};
    dy = {in_req.coord_y[COORD_W-1], in_req.coord_y} - {qy_r[COORD_W-1], qy_r};
    mag_x_nxt = dx[MAG_W-1] ? MAG_W'(~dx + 1'b1) : MAG_W'(dx);
    mag_y_nxt = dy[MAG_W-1] ? MAG_W'(~dy + 1'b1) : MAG_W'(dy);
    prod_x = mag_x_r * mag_x_r;
    prod_y = mag_y_r * mag_y_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qx_r      <= '0;
      qy_r      <= '0;
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      if (accept && in_req.action == ACT_QUERY) begin
        qx_r <= in_req.coord_x;
        qy_r <= in_req.coord_y;
      end
      if (advance) begin
        a_valid_r <= accept;
        b_valid_r <= a_valid_r;
        c_valid_r <= b_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_query_r <= (in_req.action == ACT_QUERY);
      a_last_r  <= in_req.last_candidate;
      a_idx_r   <= in_req.point_index;
      mag_x_r   <= mag_x_nxt;
      mag_y_r   <= mag_y_nxt;

      b_query_r <= a_query_r;
      b_last_r  <= a_last_r;
      b_idx_r   <= a_idx_r;
      sq_x_r    <= prod_x[SQ_W-1:0];
      sq_y_r    <= prod_y[SQ_W-1:0];

      tok_r.is_query <= b_query_r;
      tok_r.last     <= b_last_r;
      tok_r.idx      <= b_idx_r;
      tok_r.sq_dist  <= DIST_W'(sq_x_r) + DIST_W'(sq_y_r);
    end
  end

  assign tok_valid = c_valid_r;
  assign tok       = tok_r;

endmodule

[design/npswt_list.sv]
// ----------------------------------------------------------------------------
// npswt_list
// Reference distance compare, tie list memory and result sequencer.
// ----------------------------------------------------------------------------
`include "nearest_point_search_with_ties_unit_assert.svh"

module npswt_list #(
  parameter int LIST_DEPTH = npswt_pkg::LIST_DEPTH_DEF,
  parameter int INDEX_BITS = npswt_pkg::INDEX_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [15:0]           tie_tolerance,
  input  logic                  tok_valid,
  input  npswt_pkg::dist_tok_t  tok,
  output logic                  advance,
  output logic                  out_valid,
  input  logic                  out_ready,
  output npswt_pkg::out_res_t   out_res
);
  import npswt_pkg::*;

  localparam int STORE_W = (INDEX_BITS < IDX_W) ? INDEX_BITS : IDX_W;
  localparam int ADDR_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W   = $clog2(LIST_DEPTH + 1);

  typedef enum logic [1:0] {EM_IDLE, EM_READ, EM_LOAD} em_state_t;

  logic [STORE_W-1:0] mem [LIST_DEPTH];
  logic [STORE_W-1:0] rd_data_r;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              ovf_r, ovf_nxt;
  logic [DIST_W-1:0] ref_r, ref_nxt;

  em_state_t         em_state_r;
  logic [CNT_W-1:0]  rd_ptr_r, emit_cnt_r;
  logic              emit_ovf_r;
  logic              out_valid_r;
  out_res_t          out_res_r;

  logic              take, restart, emit_start, wr_en, rd_en, last_entry;
  logic              load_res, ovf_shown;
  logic              dist_lt;
  logic [ADDR_W-1:0] wr_addr;
  logic [DIST_W-1:0] diff;

  // The pipeline is frozen while a list is being sent out.
  assign advance = (em_state_r == EM_IDLE);
  assign take    = tok_valid && advance;
  assign rd_en   = (em_state_r == EM_READ);

  always_comb begin
    dist_lt = tok.sq_dist < ref_r;
    diff    = dist_lt ? (ref_r - tok.sq_dist) : (tok.sq_dist - ref_r);
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    ref_nxt = ref_r;
    wr_en   = 1'b0;
    wr_addr = cnt_r[ADDR_W-1:0];
    restart = 1'b0;
    if (take) begin
      if (tok.is_query) begin
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
      end else if (cnt_r == '0) begin
        restart = 1'b1;
      end else if (diff < DIST_W'(tie_tolerance)) begin
        if (cnt_r < CNT_W'(LIST_DEPTH)) begin
          wr_en   = 1'b1;
          cnt_nxt = CNT_W'(cnt_r + 1'b1);
        end else begin
          ovf_nxt = 1'b1;
        end
      end else if (dist_lt) begin
        restart = 1'b1;
      end
      if (restart) begin
        ref_nxt = tok.sq_dist;
        wr_en   = 1'b1;
        wr_addr = '0;
        cnt_nxt = CNT_W'(1);
        ovf_nxt = 1'b0;
      end
    end
  end

  assign emit_start = take && !tok.is_query && tok.last;
  assign last_entry = (CNT_W'(rd_ptr_r + 1'b1) == emit_cnt_r);
  assign load_res   = (em_state_r == EM_LOAD) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
      ref_r <= '0;
    end else begin
      ref_r <= ref_nxt;
      if (emit_start) begin
        cnt_r <= '0;
        ovf_r <= 1'b0;
      end else begin
        cnt_r <= cnt_nxt;
        ovf_r <= ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= tok.idx[STORE_W-1:0];
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_ptr_r[ADDR_W-1:0]];
    end
  end

  // One memory read and one output load per listed index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_state_r  <= EM_IDLE;
      out_valid_r <= 1'b0;
      rd_ptr_r    <= '0;
      emit_cnt_r  <= '0;
      emit_ovf_r  <= 1'b0;
    end else begin
      if (load_res) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (em_state_r)
        EM_IDLE: begin
          if (emit_start) begin
            rd_ptr_r   <= '0;
            emit_cnt_r <= cnt_nxt;
            emit_ovf_r <= ovf_nxt;
            em_state_r <= EM_READ;
          end
        end
        EM_READ: begin
          em_state_r <= EM_LOAD;
        end
        EM_LOAD: begin
          if (load_res) begin
            out_res_r.nearest_index   <= IDX_W'(rd_data_r);
            out_res_r.list_count      <= COUNT_W'(emit_cnt_r);
            out_res_r.list_overflow   <= emit_ovf_r;
            out_res_r.last_of_run     <= last_entry;
            rd_ptr_r                  <= CNT_W'(rd_ptr_r + 1'b1);
            em_state_r                <= last_entry ? EM_IDLE : EM_READ;
          end
        end
        default: begin
          em_state_r <= EM_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  assign ovf_shown = out_valid_r && out_res_r.list_overflow;

  `NPSWT_ASSERT_NEVER(a_cnt_bound, clk, rst_n, cnt_r > CNT_W'(LIST_DEPTH))
  `NPSWT_ASSERT_IMPL(a_list_clear_emit, clk, rst_n, em_state_r != EM_IDLE, cnt_r == '0)
  `NPSWT_ASSERT_IMPL(a_read_in_list, clk, rst_n, em_state_r == EM_READ, rd_ptr_r < emit_cnt_r)
  `NPSWT_ASSERT_IMPL(a_ovf_full, clk, rst_n, ovf_shown, out_res_r.list_count == COUNT_W'(LIST_DEPTH))

endmodule

[design/nearest_point_search_with_ties_unit.sv]
// ----------------------------------------------------------------------------
// nearest_point_search_with_ties_unit
// Streams a query point and candidate points, and returns the indices of the
// candidates nearest to the query, including those within a tie tolerance.
// The input takes one request per cycle while no list is being sent out. A
// candidate's squared distance is formed in three pipeline stages and meets
// the running reference in the fourth. When the last candidate of a search
// lands there, the input holds while the list is read out of its single-port
// memory, with one read and one output load per listed index and further
// waiting if the output stalls. Input resumes as soon as the final index sits
// in the output register.
// ----------------------------------------------------------------------------
module nearest_point_search_with_ties_unit #(
  parameter int LIST_DEPTH = npswt_pkg::LIST_DEPTH_DEF,
  parameter int INDEX_BITS = npswt_pkg::INDEX_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  npswt_pkg::in_req_t   in_req,
  output logic                 out_valid,
  input  logic                 out_ready,
  output npswt_pkg::out_res_t  out_res,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_wdata
);
  import npswt_pkg::*;

  logic [TOL_W-1:0] tol_r;
  logic             advance, tok_valid;
  dist_tok_t        tok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  assign in_ready = advance;

  npswt_dist u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_valid && in_ready),
    .in_req    (in_req),
    .advance   (advance),
    .tok_valid (tok_valid),
    .tok       (tok)
  );

  npswt_list #(
    .LIST_DEPTH (LIST_DEPTH),
    .INDEX_BITS (INDEX_BITS)
  ) u_list (
    .clk           (clk),
    .rst_n         (rst_n),
    .tie_tolerance (tol_r),
    .tok_valid     (tok_valid),
    .tok           (tok),
    .advance       (advance),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_res       (out_res)
  );

endmodule
